/* rtl/core/pcps_pkg.sv */
package pcps_pkg;

	localparam int MAX_PAIRS_DEF  = 64;
	localparam int VALUE_BITS_DEF = 16;
	localparam int OUT_BITS       = 16;
	localparam int CNT_BITS       = 7;

	typedef enum logic [1:0] {
		FAULT_NONE     = 2'd0,
		FAULT_NO_MATCH = 2'd1,
		FAULT_OVERFLOW = 2'd2
	} fault_t;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_PUSH,
		ST_POP,
		ST_RANGE,
		ST_PIVOT,
		ST_FIND,
		ST_SWAP,
		ST_SWAP2,
		ST_SCAN,
		ST_CMP,
		ST_XCH1,
		ST_XCH2,
		ST_FIN,
		ST_FIN1,
		ST_FIN2,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMIT_WAIT
	} state_t;

endpackage

/* rtl/core/pcps_if.sv */
interface pcps_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] shoe_value;
	logic [15:0] toe_value;
	logic        last_pair;
	modport source (output valid, shoe_value, toe_value, last_pair, input ready);
	modport sink (input valid, shoe_value, toe_value, last_pair, output ready);
endinterface

interface pcps_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] sorted_shoe;
	logic [15:0] sorted_toe;
	logic        final_result;
	logic [1:0]  fault;
	modport source (output valid, sorted_shoe, sorted_toe, final_result, fault, input ready);
	modport sink (input valid, sorted_shoe, sorted_toe, final_result, fault, output ready);
endinterface

/* rtl/core/pcps_ram.sv */
module pcps_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

/* rtl/core/paired_cross_partition_sorter_unit.sv */
// Collects up to MAX_PAIRS (shoe, toe) words, one per cycle while loading; extra
// words are dropped and flag fault 2. The word with last_pair set closes the set;
// the block then quicksorts both lists with cross comparisons only and streams out
// one sorted pair per word. Lists and the range stack live in synchronous memories
// with one read and one write port. A popped range is handled in steps: pop it
// and fetch the pivot shoe, search the toes for the matching toe, move it to the
// end, then per list compare each other position against the pivot, exchanging
// where needed, close by placing the pivot, and push the sub-ranges.
// A range with no matching toe stops after the search. Summed range sizes are
// about 1.4*n*log2(n) for shuffled data and up to n*n/2 for presorted data.
// Emission reads, loads and offers each pair in turn and waits until it is taken
// before reading the next one. Input is not taken while
// sorting or emitting. fault is 1 for a missing match, 2 for overflow; the first
// one seen holds for the whole set.
module paired_cross_partition_sorter_unit #(
	parameter int MAX_PAIRS  = pcps_pkg::MAX_PAIRS_DEF,
	parameter int VALUE_BITS = pcps_pkg::VALUE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	pcps_in_if.sink    in_ch,
	pcps_out_if.source out_ch
);
	import pcps_pkg::*;

	localparam int AW = $clog2(MAX_PAIRS);
	localparam int VB = VALUE_BITS;

	state_t state_q, state_d;

	logic [CNT_BITS-1:0] cnt_q, lo_q, hi_q, w_q, m_q, j_q, mt_q, sp_q, e_q;
	fault_t              fault_q;
	logic [VB-1:0]       piv_q, tmp_q;
	logic                list_q;   // 0 toes, 1 shoes
	logic                push2_q;
	logic                oval_q, fin_q;
	logic [OUT_BITS-1:0] osh_q, oto_q;

	// memories
	logic          s_we, t_we, k_we, s_re, t_re, k_re;
	logic [AW-1:0] s_wa, t_wa, k_wa, s_ra, t_ra, k_ra;
	logic [VB-1:0] s_wd, t_wd, s_rd, t_rd;
	logic [2*CNT_BITS-1:0] k_wd, k_rd;

	pcps_ram #(.DEPTH(MAX_PAIRS), .WIDTH(VB)) u_shoe (
		.clk, .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
		.rd_en(s_re), .rd_addr(s_ra), .rd_data(s_rd));
	pcps_ram #(.DEPTH(MAX_PAIRS), .WIDTH(VB)) u_toe (
		.clk, .wr_en(t_we), .wr_addr(t_wa), .wr_data(t_wd),
		.rd_en(t_re), .rd_addr(t_ra), .rd_data(t_rd));
	pcps_ram #(.DEPTH(MAX_PAIRS), .WIDTH(2*CNT_BITS)) u_stk (
		.clk, .wr_en(k_we), .wr_addr(k_wa), .wr_data(k_wd),
		.rd_en(k_re), .rd_addr(k_ra), .rd_data(k_rd));

	logic [VB-1:0]       cur_rd;
	logic [CNT_BITS-1:0] k_lo, k_hi, p_lo, p_hi;
	logic [CNT_BITS-1:0] hi_m1, k_hm1, sp_m1, j_nx, w_nx, m_nx, e_nx, n_load;
	logic                p_ok, rng_bad, match, below, ovf;
	assign cur_rd  = list_q ? s_rd : t_rd;
	assign k_lo    = k_rd[2*CNT_BITS-1:CNT_BITS];
	assign k_hi    = k_rd[CNT_BITS-1:0];
	assign hi_m1   = CNT_BITS'(hi_q - 1'b1);
	assign k_hm1   = CNT_BITS'(k_hi - 1'b1);
	assign sp_m1   = CNT_BITS'(sp_q - 1'b1);
	assign j_nx    = CNT_BITS'(j_q + 1'b1);
	assign w_nx    = CNT_BITS'(w_q + 1'b1);
	assign m_nx    = CNT_BITS'(m_q + 1'b1);
	assign e_nx    = CNT_BITS'(e_q + 1'b1);
	assign ovf     = (cnt_q == CNT_BITS'(MAX_PAIRS));
	assign n_load  = ovf ? cnt_q : CNT_BITS'(cnt_q + 1'b1);
	assign rng_bad = (k_hi > cnt_q) || (k_lo >= k_hi);
	assign match   = (t_rd == piv_q);
	assign below   = (cur_rd < piv_q);

	logic in_acc, out_acc;
	assign in_acc  = in_ch.valid && in_ch.ready;
	assign out_acc = out_ch.valid && out_ch.ready;
	assign in_ch.ready = (state_q == ST_LOAD);

	// next range to push
	always_comb begin
		p_lo = push2_q ? CNT_BITS'(mt_q + 1'b1) : lo_q;
		p_hi = push2_q ? hi_q : mt_q;
		p_ok = (p_hi > CNT_BITS'(p_lo + 1'b1)) && (sp_q < CNT_BITS'(MAX_PAIRS));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:  if (in_acc && in_ch.last_pair) state_d = ST_PUSH;
			ST_PUSH:  if (push2_q) state_d = ST_POP;
			ST_POP:   state_d = (sp_q == '0) ? ST_EMIT_RD : ST_RANGE;
			ST_RANGE: state_d = rng_bad ? ST_POP : ST_PIVOT;
			ST_PIVOT: state_d = ST_FIND;
			ST_FIND: begin
				if (match) state_d = ST_SWAP;
				else if (j_nx >= hi_q) state_d = ST_POP;
			end
			ST_SWAP:  state_d = ST_SWAP2;
			ST_SWAP2: state_d = ST_SCAN;
			ST_SCAN:  state_d = (w_nx >= hi_q) ? ST_FIN : ST_CMP;
			ST_CMP:   state_d = (below && m_q != w_q) ? ST_XCH1 : ST_SCAN;
			ST_XCH1:  state_d = ST_XCH2;
			ST_XCH2:  state_d = ST_SCAN;
			ST_FIN:   state_d = ST_FIN1;
			ST_FIN1:  state_d = ST_FIN2;
			ST_FIN2:  state_d = list_q ? ST_PUSH : ST_SCAN;
			ST_EMIT_RD: state_d = ST_EMIT_LD;
			ST_EMIT_LD: state_d = ST_EMIT_WAIT;
			ST_EMIT_WAIT: if (out_acc) state_d = fin_q ? ST_LOAD : ST_EMIT_RD;
			default:  state_d = ST_LOAD;
		endcase
	end

	// memory control
	always_comb begin
		s_we = 1'b0; t_we = 1'b0; k_we = 1'b0;
		s_re = 1'b0; t_re = 1'b0; k_re = 1'b0;
		s_wa = '0; t_wa = '0; k_wa = sp_q[AW-1:0];
		s_ra = '0; t_ra = '0; k_ra = sp_m1[AW-1:0];
		s_wd = '0; t_wd = '0; k_wd = {p_lo, p_hi};
		case (state_q)
			ST_LOAD: begin
				s_we = in_acc && !ovf;
				t_we = in_acc && !ovf;
				s_wa = cnt_q[AW-1:0];
				t_wa = cnt_q[AW-1:0];
				s_wd = VB'(in_ch.shoe_value);
				t_wd = VB'(in_ch.toe_value);
			end
			ST_PUSH:  k_we = p_ok;
			ST_POP:   k_re = (sp_q != '0);
			ST_RANGE: begin
				s_re = !rng_bad;
				s_ra = k_hm1[AW-1:0];
			end
			ST_PIVOT: begin
				t_re = 1'b1;
				t_ra = lo_q[AW-1:0];
			end
			ST_FIND: begin
				// on a hit fetch the toe at hi-1, else the next candidate
				if (match) begin
					t_re = 1'b1;
					t_ra = hi_m1[AW-1:0];
				end else if (j_nx < hi_q) begin
					t_re = 1'b1;
					t_ra = j_nx[AW-1:0];
				end
			end
			ST_SWAP: begin
				t_we = 1'b1;
				t_wa = j_q[AW-1:0];
				t_wd = t_rd;
			end
			ST_SWAP2: begin
				t_we = 1'b1;
				t_wa = hi_m1[AW-1:0];
				t_wd = piv_q;
			end
			ST_SCAN: begin
				if (w_nx < hi_q) begin
					s_re = list_q; t_re = !list_q;
					s_ra = w_q[AW-1:0]; t_ra = w_q[AW-1:0];
				end
			end
			ST_CMP: begin
				if (below && m_q != w_q) begin
					s_re = list_q; t_re = !list_q;
					s_ra = m_q[AW-1:0]; t_ra = m_q[AW-1:0];
				end
			end
			ST_XCH1: begin
				s_we = list_q; t_we = !list_q;
				s_wa = w_q[AW-1:0]; t_wa = w_q[AW-1:0];
				s_wd = cur_rd; t_wd = cur_rd;
			end
			ST_XCH2: begin
				s_we = list_q; t_we = !list_q;
				s_wa = m_q[AW-1:0]; t_wa = m_q[AW-1:0];
				s_wd = tmp_q; t_wd = tmp_q;
			end
			ST_FIN: begin
				s_re = list_q; t_re = !list_q;
				s_ra = m_q[AW-1:0]; t_ra = m_q[AW-1:0];
			end
			ST_FIN1: begin
				// slot hi-1 holds the pivot value in both lists
				s_we = list_q; t_we = !list_q;
				s_wa = hi_m1[AW-1:0]; t_wa = hi_m1[AW-1:0];
				s_wd = cur_rd; t_wd = cur_rd;
			end
			ST_FIN2: begin
				s_we = list_q; t_we = !list_q;
				s_wa = m_q[AW-1:0]; t_wa = m_q[AW-1:0];
				s_wd = piv_q; t_wd = piv_q;
			end
			ST_EMIT_RD: begin
				s_re = 1'b1; t_re = 1'b1;
				s_ra = e_q[AW-1:0]; t_ra = e_q[AW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			w_q     <= '0;
			m_q     <= '0;
			j_q     <= '0;
			mt_q    <= '0;
			sp_q    <= '0;
			e_q     <= '0;
			fault_q <= FAULT_NONE;
			piv_q   <= '0;
			tmp_q   <= '0;
			list_q  <= 1'b0;
			push2_q <= 1'b0;
			oval_q  <= 1'b0;
			fin_q   <= 1'b0;
			osh_q   <= '0;
			oto_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOAD: if (in_acc) begin
					if (!ovf) cnt_q <= CNT_BITS'(cnt_q + 1'b1);
					else if (fault_q == FAULT_NONE) fault_q <= FAULT_OVERFLOW;
					if (in_ch.last_pair) begin
						// first push is (0, n); the second, (n+1, n), is empty
						lo_q    <= '0;
						hi_q    <= n_load;
						mt_q    <= n_load;
						push2_q <= 1'b0;
						sp_q    <= '0;
					end
				end
				ST_PUSH: begin
					if (p_ok) sp_q <= CNT_BITS'(sp_q + 1'b1);
					push2_q <= !push2_q;
				end
				ST_POP: begin
					if (sp_q != '0) sp_q <= sp_m1;
					e_q <= '0;
				end
				ST_RANGE: begin
					lo_q <= k_lo;
					hi_q <= k_hi;
				end
				ST_PIVOT: begin
					piv_q <= s_rd;
					j_q   <= lo_q;
				end
				ST_FIND: begin
					if (!match) begin
						j_q <= j_nx;
						if (j_nx >= hi_q && fault_q == FAULT_NONE)
							fault_q <= FAULT_NO_MATCH;
					end
				end
				ST_SWAP2: begin
					list_q <= 1'b0;
					w_q    <= lo_q;
					m_q    <= lo_q;
				end
				ST_CMP: begin
					if (below && m_q != w_q) begin
						tmp_q <= cur_rd;
					end else begin
						w_q <= w_nx;
						if (below) m_q <= m_nx;
					end
				end
				ST_XCH2: begin
					w_q <= w_nx;
					m_q <= m_nx;
				end
				ST_FIN2: begin
					if (!list_q) begin
						mt_q   <= m_q;
						list_q <= 1'b1;
						w_q    <= lo_q;
						m_q    <= lo_q;
					end else begin
						if (m_q != mt_q && fault_q == FAULT_NONE)
							fault_q <= FAULT_NO_MATCH;
						push2_q <= 1'b0;
					end
				end
				ST_EMIT_LD: begin
					osh_q  <= OUT_BITS'(s_rd);
					oto_q  <= OUT_BITS'(t_rd);
					fin_q  <= (e_nx == cnt_q);
					oval_q <= 1'b1;
				end
				ST_EMIT_WAIT: begin
					if (out_acc) begin
						oval_q <= 1'b0;
						e_q    <= e_nx;
						if (fin_q) begin
							cnt_q   <= '0;
							fault_q <= FAULT_NONE;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign out_ch.valid        = oval_q;
	assign out_ch.sorted_shoe  = osh_q;
	assign out_ch.sorted_toe   = oto_q;
	assign out_ch.final_result = fin_q;
	assign out_ch.fault        = fault_q;

`ifndef SYNTH
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> (state_q == ST_LOAD)) else $error("ready while busy");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_BITS'(MAX_PAIRS)) else $error("count overflow");
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= CNT_BITS'(MAX_PAIRS)) else $error("stack overflow");
	a_fault_code: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q == FAULT_NONE || fault_q == FAULT_NO_MATCH || fault_q == FAULT_OVERFLOW)
		else $error("bad fault code");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid
		&& $stable({out_ch.sorted_shoe, out_ch.sorted_toe, out_ch.final_result, out_ch.fault}))
		else $error("output changed while stalled");
`endif
endmodule
